// ----- rtl/core/lru_byte_budget_cache_policy_assert.svh -----
// ----------------------------------------------------------------------------
// LRU byte budget cache policy assertion macros
// Shared property macros for the checker.
// ----------------------------------------------------------------------------
`ifndef LRU_BYTE_BUDGET_CACHE_POLICY_ASSERT_SVH
`define LRU_BYTE_BUDGET_CACHE_POLICY_ASSERT_SVH

// same-cycle implication, reset disables
`define LBB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbb: same-cycle property failed");

// next-cycle implication, reset disables
`define LBB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbb: next-cycle property failed");

`endif

// ----- rtl/core/lbb_pkg.sv -----
// ----------------------------------------------------------------------------
// lbb_pkg
// Types and constants shared by the LRU byte budget cache policy.
// ----------------------------------------------------------------------------
package lbb_pkg;

	localparam int SIZE_W = 21;
	localparam int KIND_W = 3;
	localparam int REQ_KEY_W = 64;
	localparam logic [SIZE_W-1:0] BUDGET_RESET = 21'd1048576;

	localparam logic [KIND_W-1:0] KIND_HIT    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MISS   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EVICT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REJECT = 3'd4;

	typedef struct packed {
		logic load;
		logic scan_step;
		logic lk_done;
		logic reject;
		logic evict;
		logic insert;
	} cmd_t;

	typedef struct packed {
		logic req_insert;
		logic too_big;
		logic scan_last;
		logic fits;
		logic empty;
	} sts_t;

endpackage

// ----- rtl/core/lbb_ctrl.sv -----
// ----------------------------------------------------------------------------
// lbb_ctrl
// Sequencer: lookup scan, eviction loop, insert and reject.
// ----------------------------------------------------------------------------
module lbb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lbb_pkg::sts_t sts,
	output lbb_pkg::cmd_t cmd,
	output logic          busy
);
	import lbb_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_LKDONE = 5'b00100,
		S_EVICT  = 5'b01000,
		S_REJECT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!sts.req_insert) begin
						state_d = S_SCAN;
					end else if (sts.too_big) begin
						state_d = S_REJECT;
					end else begin
						state_d = S_EVICT;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_LKDONE;
				end
			end
			S_LKDONE: begin
				cmd.lk_done = 1'b1;
				state_d     = S_IDLE;
			end
			S_EVICT: begin
				if (!sts.fits && !sts.empty) begin
					cmd.evict = 1'b1;
				end else begin
					cmd.insert = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_REJECT: begin
				cmd.reject = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- rtl/core/lbb_dpath.sv -----
// ----------------------------------------------------------------------------
// lbb_dpath
// Entry table, recency ranks, byte total and result registers.
// ----------------------------------------------------------------------------
module lbb_dpath #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 64,
	parameter int SLOT_W   = $clog2(ENTRIES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lbb_pkg::cmd_t                cmd,
	output lbb_pkg::sts_t                sts,
	input  logic [lbb_pkg::SIZE_W-1:0]   budget,
	input  logic                         opcode,
	input  logic [lbb_pkg::REQ_KEY_W-1:0] key,
	input  logic [lbb_pkg::SIZE_W-1:0]   object_size,
	output logic                         done,
	output logic [lbb_pkg::KIND_W-1:0]   kind,
	output logic [SLOT_W-1:0]            slot,
	output logic [lbb_pkg::SIZE_W-1:0]   freed_size,
	output logic [lbb_pkg::SIZE_W-1:0]   bytes_in_use,
	output logic                         last
);
	import lbb_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic [ENTRIES-1:0]  valid_q;
	logic [KEY_BITS-1:0] key_q  [ENTRIES];
	logic [SIZE_W-1:0]   size_q [ENTRIES];
	logic [SLOT_W-1:0]   rank_q [ENTRIES];
	logic [CNT_W-1:0]    n_q;
	logic [SIZE_W-1:0]   total_q;

	logic [KEY_BITS-1:0] req_key_q;
	logic [SIZE_W-1:0]   req_size_q;
	logic [SLOT_W-1:0]   idx_q;
	logic                found_q;
	logic [SLOT_W-1:0]   best_q;
	logic [SLOT_W-1:0]   best_rank_q;

	logic                done_q, last_q;
	logic [KIND_W-1:0]   kind_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SIZE_W-1:0]   freed_q;

	logic                cur_match;
	logic [SLOT_W-1:0]   free_slot, old_slot;
	logic                has_free;
	logic [SIZE_W:0]     need;
	logic [SIZE_W-1:0]   freed_now;

	always_comb begin
		free_slot = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
		old_slot = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (valid_q[i] && (CNT_W'(rank_q[i]) == n_q - CNT_W'(1))) begin
				old_slot = SLOT_W'(i);
			end
		end
	end

	assign has_free  = ~&valid_q;
	assign need      = {1'b0, total_q} + {1'b0, req_size_q};
	assign freed_now = size_q[old_slot];
	assign cur_match = valid_q[idx_q] && (key_q[idx_q] == req_key_q) &&
	                   (!found_q || rank_q[idx_q] < best_rank_q);

	assign sts.req_insert = opcode;
	assign sts.too_big    = (object_size > budget);
	assign sts.scan_last  = (idx_q == SLOT_W'(ENTRIES - 1));
	assign sts.fits       = (need <= {1'b0, budget}) && has_free;
	assign sts.empty      = (n_q == '0);

	// request and scan registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_key_q  <= key[KEY_BITS-1:0];
			req_size_q <= object_size;
			idx_q      <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + SLOT_W'(1);
		end
		if (cmd.scan_step && cur_match) begin
			best_q      <= idx_q;
			best_rank_q <= rank_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.load) begin
			found_q <= 1'b0;
		end else if (cmd.scan_step && cur_match) begin
			found_q <= 1'b1;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.lk_done && found_q && valid_q[i]) begin
				if (SLOT_W'(i) == best_q) begin
					rank_q[i] <= '0;
				end else if (rank_q[i] < best_rank_q) begin
					rank_q[i] <= rank_q[i] + SLOT_W'(1);
				end
			end
			if (cmd.insert) begin
				if (SLOT_W'(i) == free_slot) begin
					key_q[i]  <= req_key_q;
					size_q[i] <= req_size_q;
					rank_q[i] <= '0;
				end else if (valid_q[i]) begin
					rank_q[i] <= rank_q[i] + SLOT_W'(1);
				end
			end
		end
	end

	// valid bits, count and byte total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			n_q     <= '0;
			total_q <= '0;
		end else if (cmd.evict) begin
			valid_q[old_slot] <= 1'b0;
			n_q               <= n_q - CNT_W'(1);
			total_q           <= (total_q >= freed_now) ? total_q - freed_now : '0;
		end else if (cmd.insert) begin
			valid_q[free_slot] <= 1'b1;
			n_q                <= n_q + CNT_W'(1);
			total_q            <= need[SIZE_W-1:0];
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.lk_done | cmd.reject | cmd.evict | cmd.insert;
		end
	end

	always_ff @(posedge clk) begin
		last_q  <= !cmd.evict;
		freed_q <= '0;
		slot_q  <= '0;
		kind_q  <= KIND_REJECT;
		if (cmd.lk_done) begin
			kind_q <= found_q ? KIND_HIT : KIND_MISS;
			slot_q <= found_q ? best_q : '0;
		end else if (cmd.evict) begin
			kind_q  <= KIND_EVICT;
			slot_q  <= old_slot;
			freed_q <= freed_now;
		end else if (cmd.insert) begin
			kind_q <= KIND_INSERT;
			slot_q <= free_slot;
		end
	end

	assign done         = done_q;
	assign kind         = kind_q;
	assign slot         = slot_q;
	assign freed_size   = freed_q;
	assign bytes_in_use = total_q;
	assign last         = last_q;

endmodule

// ----- rtl/core/lru_byte_budget_cache_policy.sv -----
// ----------------------------------------------------------------------------
// lru_byte_budget_cache_policy
// Size-aware LRU replacement policy over a small table of cached objects.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. opcode 0 looks up
//   key, opcode 1 inserts key with object_size bytes.
//   Each result beat shows on kind/slot/freed_size/bytes_in_use/last for one
//   cycle with done high; last marks the final beat of a request. Beats
//   cannot be held off.
//   Lookup: one entry compared per cycle over the whole table, then the beat.
//   Insert: one eviction beat per cycle, then the insert beat. Reject: one
//   beat. busy falls with the last beat, so the next request may be taken in
//   that cycle. byte_budget is written over the APB port (address 0); the
//   user must write it only while idle, as the block does not enforce it.
//   Reset empties the table, clears the byte total and loads the default
//   budget; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_byte_budget_cache_policy #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [2:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 opcode,
	input  logic [lbb_pkg::REQ_KEY_W-1:0]        key,
	input  logic [lbb_pkg::SIZE_W-1:0]           object_size,
	output logic                                 done,
	output logic [lbb_pkg::KIND_W-1:0]           kind,
	output logic [$clog2(ENTRIES)-1:0]           slot,
	output logic [lbb_pkg::SIZE_W-1:0]           freed_size,
	output logic [lbb_pkg::SIZE_W-1:0]           bytes_in_use,
	output logic                                 last
);
	import lbb_pkg::*;

	localparam int SLOT_W = $clog2(ENTRIES);

	logic [SIZE_W-1:0] budget_q;
	cmd_t              cmd;
	sts_t              sts;
	logic              ctrl_busy;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32 - SIZE_W){1'b0}}, budget_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			budget_q <= pwdata[SIZE_W-1:0];
		end
	end

	lbb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (ctrl_busy)
	);

	lbb_dpath #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS),
		.SLOT_W   (SLOT_W)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.budget       (budget_q),
		.opcode       (opcode),
		.key          (key),
		.object_size  (object_size),
		.done         (done),
		.kind         (kind),
		.slot         (slot),
		.freed_size   (freed_size),
		.bytes_in_use (bytes_in_use),
		.last         (last)
	);

	assign busy = ctrl_busy;

endmodule

// ----- rtl/core/lbb_chk.sv -----
// ----------------------------------------------------------------------------
// lbb_chk
// Port-level checker for the LRU byte budget cache policy, bound to the top.
// ----------------------------------------------------------------------------
`include "lru_byte_budget_cache_policy_assert.svh"

module lbb_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [lbb_pkg::KIND_W-1:0]    kind,
	input logic                          last
);
	import lbb_pkg::*;

	`LBB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`LBB_ASSERT_NOW(a_last_idle, done && last, !busy)
	`LBB_ASSERT_NOW(a_more_busy, done && !last, busy)
	`LBB_ASSERT_NOW(a_evict_not_last, done && (kind == KIND_EVICT), !last)
	`LBB_ASSERT_NOW(a_kind_legal, done, kind <= KIND_REJECT)

endmodule

bind lru_byte_budget_cache_policy lbb_chk u_lbb_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.kind   (kind),
	.last   (last)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU byte budget cache policy testbench
// Drives lookups and inserts through the command port and writes the budget
// over APB while the block is idle. A table of directed requests runs first.
// Random traffic on a small key pool follows. Every result beat is compared
// with a local model of the cache table.
// ----------------------------------------------------------------------------
module tb;
	import lbb_pkg::*;

	localparam int ENTRIES = 16;
	localparam int WD_LIMIT = 4000;
	localparam logic [2:0] ADDR_BUDGET = 3'd0;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [3:0]        slot;
		logic [SIZE_W-1:0] freed;
		logic [SIZE_W-1:0] in_use;
		logic              last;
	} beat_t;

	typedef struct {
		logic              op;
		logic [63:0]       k;
		logic [SIZE_W-1:0] sz;
		logic              chk;
		logic [KIND_W-1:0] kind;
		logic [3:0]        slot;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready, start = 0, busy, opcode = 0, done, last;
	logic [63:0] key = '0;
	logic [SIZE_W-1:0] object_size = '0, freed_size, bytes_in_use;
	logic [KIND_W-1:0] kind;
	logic [3:0] slot;

	lru_byte_budget_cache_policy u_top (.*);

	always #2 clk = ~clk;

	logic [SIZE_W-1:0] m_budget, m_total;
	logic              m_valid [ENTRIES];
	logic [63:0]       m_key [ENTRIES];
	logic [SIZE_W-1:0] m_size [ENTRIES];
	int unsigned       m_rank [ENTRIES];
	beat_t exp_beats[$];
	int errors = 0, idle_cycles = 0;
	logic accepted;

	function automatic int free_slot();
		for (int i = 0; i < ENTRIES; i++) if (!m_valid[i]) return i;
		return -1;
	endfunction

	function automatic int oldest_slot();
		int b;
		b = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (m_valid[i] && (b < 0 || m_rank[i] > m_rank[b])) b = i;
		return b;
	endfunction

	function automatic void push(logic [KIND_W-1:0] kd, int s, logic [SIZE_W-1:0] f,
			logic l);
		beat_t b;
		b.kind = kd; b.slot = s[3:0]; b.freed = f; b.in_use = m_total; b.last = l;
		exp_beats.push_back(b);
	endfunction

	function automatic void predict_cache(logic op, logic [63:0] k, logic [SIZE_W-1:0] sz);
		int h, v, s;
		logic [SIZE_W-1:0] fr;
		logic [SIZE_W:0] sum;
		if (!op) begin
			h = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (m_valid[i] && m_key[i] == k && (h < 0 || m_rank[i] < m_rank[h])) h = i;
			if (h < 0) begin
				push(KIND_MISS, 0, 0, 1);
			end else begin
				for (int i = 0; i < ENTRIES; i++)
					if (m_valid[i] && i != h && m_rank[i] < m_rank[h]) m_rank[i]++;
				m_rank[h] = 0;
				push(KIND_HIT, h, 0, 1);
			end
			return;
		end
		if (sz > m_budget) begin
			push(KIND_REJECT, 0, 0, 1);
			return;
		end
		forever begin
			sum = {1'b0, m_total} + {1'b0, sz};
			if (sum <= {1'b0, m_budget} && free_slot() >= 0) break;
			v = oldest_slot();
			if (v < 0) break;
			fr = m_size[v];
			m_valid[v] = 0;
			m_total = (m_total >= fr) ? m_total - fr : '0;
			push(KIND_EVICT, v, fr, 0);
		end
		s = free_slot();
		if (s < 0) s = 0;
		for (int i = 0; i < ENTRIES; i++) if (m_valid[i]) m_rank[i]++;
		m_valid[s] = 1; m_key[s] = k; m_size[s] = sz; m_rank[s] = 0;
		m_total = m_total + sz;
		push(KIND_INSERT, s, 0, 1);
	endfunction

	// result checker
	always @(posedge clk) begin
		beat_t e;
		if (arst_n && done) begin
			if (exp_beats.size() == 0) begin
				$error("unexpected beat kind=%0d slot=%0d", kind, slot);
				errors++;
			end else begin
				e = exp_beats.pop_front();
				if (kind !== e.kind) begin
					$error("kind exp %0d got %0d", e.kind, kind); errors++;
				end
				if (slot !== e.slot) begin
					$error("slot exp %0d got %0d", e.slot, slot); errors++;
				end
				if (freed_size !== e.freed) begin
					$error("freed_size exp %0d got %0d", e.freed, freed_size); errors++;
				end
				if (bytes_in_use !== e.in_use) begin
					$error("bytes_in_use exp %0d got %0d", e.in_use, bytes_in_use); errors++;
				end
				if (last !== e.last) begin
					$error("last exp %0d got %0d", e.last, last); errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		accepted = (start && !busy) || done || (psel && penable);
		idle_cycles = accepted ? 0 : idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_req(logic op, logic [63:0] k, logic [SIZE_W-1:0] sz);
		start <= 1; opcode <= op; key <= k; object_size <= sz;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_cache(op, k, sz);
		@(negedge clk);
		start <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (exp_beats.size() != 0) @(negedge clk);
		repeat (ENTRIES + 4) @(negedge clk);
	endtask

	task automatic write_budget(logic [SIZE_W-1:0] v);
		drain();
		psel <= 1; pwrite <= 1; paddr <= ADDR_BUDGET; pwdata <= {11'h0, v};
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		m_budget = v;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	row_t rows[$];

	function automatic void add(logic op, logic [63:0] k, logic [SIZE_W-1:0] sz,
			logic chk = 0, logic [KIND_W-1:0] kd = KIND_MISS, logic [3:0] s = 0);
		row_t r;
		r.op = op; r.k = k; r.sz = sz; r.chk = chk; r.kind = kd; r.slot = s;
		rows.push_back(r);
	endfunction

	logic [63:0] pool[8];
	logic [SIZE_W-1:0] sz_r;
	logic [SIZE_W-1:0] budgets[5];

	initial begin
		m_budget = BUDGET_RESET; m_total = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			m_valid[i] = 0; m_key[i] = 0; m_size[i] = 0; m_rank[i] = 0;
		end
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		add(0, 64'h0, 0, 1, KIND_MISS, 0);
		add(1, 64'hFFFF_FFFF_FFFF_FFFF, 21'h1FFFFF, 1, KIND_REJECT, 0);
		add(1, 64'h0, 0, 1, KIND_INSERT, 0);
		add(1, 64'hFFFF_FFFF_FFFF_FFFF, 21'd1048576, 1, KIND_INSERT, 1);
		add(0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1, KIND_HIT, 1);
		add(0, 64'h0, 21'h1FFFFF, 1, KIND_HIT, 0);
		add(1, 64'h1234, 21'd5);
		add(1, 64'h1234, 21'd7);
		add(0, 64'h1234, 0);
		add(1, 64'hA5A5_5A5A_0F0F_F0F0, 21'd100);
		for (int i = 0; i < 14; i++) add(1, 64'h100 + i, 21'd1000 + SIZE_W'(i));
		foreach (rows[i]) begin
			if (rows[i].chk) begin
				while (exp_beats.size() != 0) @(negedge clk);
				send_req(rows[i].op, rows[i].k, rows[i].sz);
				if (exp_beats[$].kind !== rows[i].kind || exp_beats[$].slot !== rows[i].slot) begin
					$error("directed row %0d table kind %0d slot %0d", i, rows[i].kind,
						rows[i].slot);
					errors++;
				end
			end else begin
				send_req(rows[i].op, rows[i].k, rows[i].sz);
			end
		end
		// budget lowered below the total; next insert evicts
		write_budget(21'd2000);
		send_req(0, 64'h100, 0);
		send_req(1, 64'h77, 21'd10);

		budgets[0] = 0; budgets[1] = 21'h1FFFFF; budgets[2] = 21'd5000;
		budgets[3] = 21'd300; budgets[4] = BUDGET_RESET;
		for (int ph = 0; ph < 5; ph++) begin
			write_budget(budgets[ph]);
			for (int i = 0; i < 8; i++) pool[i] = {$urandom, $urandom};
			for (int n = 0; n < 15; n++) begin
				case ($urandom_range(0, 3))
					0: sz_r = SIZE_W'($urandom);
					1: sz_r = 21'h1FFFFF;
					default: sz_r = SIZE_W'($urandom_range(0, (budgets[ph] >> 3) + 1));
				endcase
				if ($urandom_range(0, 9) == 0)
					send_req(1'($urandom_range(0, 1)), {$urandom, $urandom}, sz_r);
				else
					send_req(1'($urandom_range(0, 1)), pool[$urandom_range(0, 7)], sz_r);
				gap();
			end
		end

		fork
			drain();
			begin
				repeat (200000) @(negedge clk);
				$display("Regression FAIL");
				$finish;
			end
		join_any
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ----- lru_byte_budget_cache_policy.f -----
+incdir+rtl/core
rtl/core/lbb_pkg.sv
rtl/core/lbb_ctrl.sv
rtl/core/lbb_dpath.sv
rtl/core/lru_byte_budget_cache_policy.sv
rtl/core/lbb_chk.sv
dv/tb.sv
